FILE: rtl/core/bike_speed_cadence_calc_defines.svh
// Assertion macros for the bike speed and cadence calculator.
// Included by bike_speed_cadence_calc.sv, which carries the concurrent checks; no other dependencies.
`ifndef BIKE_SPEED_CADENCE_CALC_DEFINES_SVH
`define BIKE_SPEED_CADENCE_CALC_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define BSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsc assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsc assertion failed");
`else
`define BSC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/bsc_pkg.sv
// Shared types and constants for the bike speed and cadence calculator.
// No dependencies; used by the report interface and the top level.
package bsc_pkg;

    localparam int COEF_W   = 24;
    localparam int CAD_W    = 16;
    localparam int RESULT_W = 32;
    localparam int APB_DW   = 32;
    localparam int ADDR_W   = 3;

    localparam logic [COEF_W-1:0] SPEED_COEF_RESET   = 24'd7630848;
    localparam logic [CAD_W-1:0]  CADENCE_COEF_RESET = 16'd61440;

    // Register index, taken from paddr[2].
    localparam logic REG_SPEED_COEF   = 1'b0;
    localparam logic REG_CADENCE_COEF = 1'b1;

    // Channel select.
    localparam logic CH_SPEED   = 1'b0;
    localparam logic CH_CADENCE = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

FILE: rtl/core/bsc_if.sv
// Valid/ready channel interfaces for sensor pages in and computed reports out.
// Depends on bsc_pkg for the result width.
interface bsc_page_if #(
    parameter int COUNTER_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic [COUNTER_BITS-1:0] speed_rev_count;
    logic [COUNTER_BITS-1:0] speed_event_time;
    logic [COUNTER_BITS-1:0] cadence_rev_count;
    logic [COUNTER_BITS-1:0] cadence_event_time;

    modport source (
        output valid, speed_rev_count, speed_event_time,
               cadence_rev_count, cadence_event_time,
        input  ready
    );
    modport sink (
        input  valid, speed_rev_count, speed_event_time,
               cadence_rev_count, cadence_event_time,
        output ready
    );
endinterface

interface bsc_report_if;
    import bsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] speed_value;
    logic [RESULT_W-1:0] cadence_value;
    logic                speed_updated;
    logic                cadence_updated;
    logic                speed_time_fault;
    logic                cadence_time_fault;

    modport source (
        output valid, speed_value, cadence_value, speed_updated, cadence_updated,
               speed_time_fault, cadence_time_fault,
        input  ready
    );
    modport sink (
        input  valid, speed_value, cadence_value, speed_updated, cadence_updated,
               speed_time_fault, cadence_time_fault,
        output ready
    );
endinterface

FILE: rtl/core/bike_speed_cadence_calc.sv
// Bike speed and cadence calculator: one report beat for every sensor page beat.
// A page is accepted in IDLE; each channel then passes CHECK and, when recomputed, MUL and DIV;
// DONE loads the output register and returns to IDLE.
// One page at a time: the next page is taken only back in IDLE, once the shared bit-serial
// multiplier and divider are free; a finished report waits in the output register meanwhile.
// Reset (rst_n, asynchronous, active low) clears channel state and loads default coefficients.
`include "bike_speed_cadence_calc_defines.svh"

module bike_speed_cadence_calc #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB-style configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bsc_pkg::APB_DW-1:0]  pwdata,
    output logic [bsc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    // Data channels
    bsc_page_if.sink                    page,
    bsc_report_if.source                report
);
    import bsc_pkg::*;

    // The product of a coefficient and a count delta needs PROD_W bits. The same
    // shift register first accumulates the product, then serves as the dividend
    // and collects the quotient one bit per cycle.
    localparam int PROD_W = COEF_W + COUNTER_BITS;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(COUNTER_BITS);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(PROD_W);

    // Configuration registers.
    logic [COEF_W-1:0] spd_coef_reg;
    logic [CAD_W-1:0]  cad_coef_reg;
    logic              cfg_write;

    // Sequencer and datapath registers.
    state_t                  state_reg, state_next;
    logic                    ch_reg, ch_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic [COUNTER_BITS:0]   rem_reg, rem_next;
    logic [COUNTER_BITS-1:0] dtime_reg, dtime_next;

    // Latched page fields, indexed by channel.
    logic [COUNTER_BITS-1:0] count_in_reg [2];
    logic [COUNTER_BITS-1:0] count_in_next [2];
    logic [COUNTER_BITS-1:0] time_in_reg [2];
    logic [COUNTER_BITS-1:0] time_in_next [2];

    // Per-channel history and results.
    logic [COUNTER_BITS-1:0] last_count_reg [2];
    logic [COUNTER_BITS-1:0] last_count_next [2];
    logic [COUNTER_BITS-1:0] last_time_reg [2];
    logic [COUNTER_BITS-1:0] last_time_next [2];
    logic [RESULT_W-1:0]     result_reg [2];
    logic [RESULT_W-1:0]     result_next [2];
    logic [1:0]              upd_reg, upd_next;
    logic [1:0]              fault_reg, fault_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [RESULT_W-1:0] out_spd_reg, out_spd_next;
    logic [RESULT_W-1:0] out_cad_reg, out_cad_next;
    logic [1:0]          out_upd_reg, out_upd_next;
    logic [1:0]          out_fault_reg, out_fault_next;

    // Datapath helpers.
    logic [COEF_W-1:0]       coef_sel;
    logic [COUNTER_BITS-1:0] dcount;
    logic [COUNTER_BITS-1:0] dtime;
    logic [COEF_W:0]         mul_sum;
    logic [COUNTER_BITS:0]   div_shift;
    logic                    div_ge;
    logic [PROD_W-1:0]       quot;
    logic [RESULT_W-1:0]     quot_sat;

    // ------------------------------------------------------------------
    // Configuration port: zero-wait writes, combinational read-back.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_SPEED_COEF:   prdata = APB_DW'(spd_coef_reg);
            REG_CADENCE_COEF: prdata = APB_DW'(cad_coef_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spd_coef_reg <= SPEED_COEF_RESET;
            cad_coef_reg <= CADENCE_COEF_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SPEED_COEF:   spd_coef_reg <= pwdata[COEF_W-1:0];
                REG_CADENCE_COEF: cad_coef_reg <= pwdata[CAD_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshakes. A page is taken only while the sequencer is idle; the
    // report waits in its own register, so the next page may enter early.
    // ------------------------------------------------------------------
    assign page.ready                = (state_reg == ST_IDLE);
    assign report.valid              = out_valid_reg;
    assign report.speed_value        = out_spd_reg;
    assign report.cadence_value      = out_cad_reg;
    assign report.speed_updated      = out_upd_reg[CH_SPEED];
    assign report.cadence_updated    = out_upd_reg[CH_CADENCE];
    assign report.speed_time_fault   = out_fault_reg[CH_SPEED];
    assign report.cadence_time_fault = out_fault_reg[CH_CADENCE];

    // ------------------------------------------------------------------
    // Datapath: wrapped deltas, one shift-add multiply step and one
    // restoring divide step.
    // ------------------------------------------------------------------
    assign coef_sel = (ch_reg == CH_CADENCE) ? COEF_W'(cad_coef_reg) : spd_coef_reg;
    assign dcount   = count_in_reg[ch_reg] - last_count_reg[ch_reg];
    assign dtime    = time_in_reg[ch_reg] - last_time_reg[ch_reg];

    // Multiplier: the low part of acc holds the remaining multiplier bits,
    // the high part the running sum; both shift right one place a cycle.
    assign mul_sum = {1'b0, acc_reg[PROD_W-1:COUNTER_BITS]}
                   + (acc_reg[0] ? {1'b0, coef_sel} : '0);

    // Divider: the dividend leaves acc at the top, quotient bits enter at
    // the bottom. The partial remainder stays below the divisor.
    assign div_shift = {rem_reg[COUNTER_BITS-1:0], acc_reg[PROD_W-1]};
    assign div_ge    = (div_shift >= {1'b0, dtime_reg});

    // The quotient from the last divide step, clamped to 32 bits.
    assign quot     = {acc_reg[PROD_W-2:0], div_ge};
    assign quot_sat = ((quot >> RESULT_W) != '0) ? '1 : quot[RESULT_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer: each channel goes through CHECK, then MUL and DIV only
    // when its count moved and its time delta is nonzero.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        dtime_next     = dtime_reg;
        count_in_next  = count_in_reg;
        time_in_next   = time_in_reg;
        last_count_next = last_count_reg;
        last_time_next = last_time_reg;
        result_next    = result_reg;
        upd_next       = upd_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg;
        out_spd_next   = out_spd_reg;
        out_cad_next   = out_cad_reg;
        out_upd_next   = out_upd_reg;
        out_fault_next = out_fault_reg;

        if (report.valid && report.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (page.valid)
                begin
                    count_in_next[CH_SPEED]   = page.speed_rev_count;
                    time_in_next[CH_SPEED]    = page.speed_event_time;
                    count_in_next[CH_CADENCE] = page.cadence_rev_count;
                    time_in_next[CH_CADENCE]  = page.cadence_event_time;
                    ch_next    = CH_SPEED;
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                upd_next[ch_reg]   = 1'b0;
                fault_next[ch_reg] = 1'b0;
                if (dcount == '0)
                begin
                    // Count unchanged: keep history and result, clear the flags for this channel.
                    ch_next    = CH_CADENCE;
                    state_next = (ch_reg == CH_CADENCE) ? ST_DONE : ST_CHECK;
                end
                else
                begin
                    last_count_next[ch_reg] = count_in_reg[ch_reg];
                    last_time_next[ch_reg]  = time_in_reg[ch_reg];
                    if (dtime == '0)
                    begin
                        // No time elapsed: keep the old result, flag it.
                        fault_next[ch_reg] = 1'b1;
                        ch_next    = CH_CADENCE;
                        state_next = (ch_reg == CH_CADENCE) ? ST_DONE : ST_CHECK;
                    end
                    else
                    begin
                        acc_next   = PROD_W'(dcount);
                        dtime_next = dtime;
                        cnt_next   = MUL_STEPS;
                        state_next = ST_MUL;
                    end
                end
            end

            ST_MUL:
            begin
                acc_next = {mul_sum, acc_reg[COUNTER_BITS-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    rem_next   = '0;
                    cnt_next   = DIV_STEPS;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                acc_next = quot;
                rem_next = div_ge ? (div_shift - {1'b0, dtime_reg}) : div_shift;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    result_next[ch_reg] = quot_sat;
                    upd_next[ch_reg]    = 1'b1;
                    ch_next    = CH_CADENCE;
                    state_next = (ch_reg == CH_CADENCE) ? ST_DONE : ST_CHECK;
                end
            end

            ST_DONE:
            begin
                // Load the report once the output register is free or draining.
                if (!out_valid_reg || report.ready)
                begin
                    out_valid_next = 1'b1;
                    out_spd_next   = result_reg[CH_SPEED];
                    out_cad_next   = result_reg[CH_CADENCE];
                    out_upd_next   = upd_reg;
                    out_fault_next = fault_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and channel state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ch_reg         <= CH_SPEED;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            upd_reg        <= '0;
            fault_reg      <= '0;
            for (int i = 0; i < 2; i++)
            begin
                last_count_reg[i] <= '0;
                last_time_reg[i]  <= '0;
                result_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            ch_reg         <= ch_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            upd_reg        <= upd_next;
            fault_reg      <= fault_next;
            last_count_reg <= last_count_next;
            last_time_reg  <= last_time_next;
            result_reg     <= result_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        dtime_reg     <= dtime_next;
        count_in_reg  <= count_in_next;
        time_in_reg   <= time_in_next;
        out_spd_reg   <= out_spd_next;
        out_cad_reg   <= out_cad_next;
        out_upd_reg   <= out_upd_next;
        out_fault_reg <= out_fault_next;
    end

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `BSC_ASSERT_IMPL(a_divisor_nonzero, clk, rst_n, (state_reg == ST_MUL) || (state_reg == ST_DIV), dtime_reg != '0)
    `BSC_ASSERT_IMPL(a_flags_exclusive, clk, rst_n, report.valid, (out_upd_reg & out_fault_reg) == 2'b00)
    `BSC_ASSERT_NEXT(a_page_starts_speed, clk, rst_n, page.valid && page.ready, (state_reg == ST_CHECK) && (ch_reg == CH_SPEED))
    `BSC_ASSERT_NEXT(a_done_loads_report, clk, rst_n, (state_reg == ST_DONE) && (!out_valid_reg || report.ready), report.valid && (state_reg == ST_IDLE))

endmodule
